// ----- hw/rtl/prim_minimum_spanning_tree_core_assert.svh -----
// Assertion macros for the spanning tree core.
// Depends on nothing; included by the top level.
`ifndef PRIM_MINIMUM_SPANNING_TREE_CORE_ASSERT_SVH
`define PRIM_MINIMUM_SPANNING_TREE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PMST_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmst assertion failed");
`define PMST_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmst assertion failed");
`else
`define PMST_ASSERT_IMP(label, clk, rst, ante, cons)
`define PMST_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/pmst_pkg.sv -----
// Shared types and constants of the spanning tree core.
// Used by every module of the block but the RAM; depends on nothing.
package pmst_pkg;

  localparam int MAX_NODES_DEFAULT = 16;
  localparam int WEIGHT_W          = 10;
  localparam int COST_W            = 14;
  localparam int PORT_IDX_W        = 4;
  localparam int NODE_COUNT_W      = 5;

  localparam logic [WEIGHT_W-1:0]     NO_EDGE_WEIGHT   = 10'd1000;
  localparam logic [COST_W-1:0]       COST_MAX         = 14'd16383;
  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 5'd16;

  typedef struct packed {
    logic [PORT_IDX_W-1:0] row_index;
    logic [PORT_IDX_W-1:0] col_index;
    logic [WEIGHT_W-1:0]   edge_weight_in;
    logic                  last_entry;
  } item_t;

  typedef struct packed {
    logic [PORT_IDX_W-1:0] edge_from;
    logic [PORT_IDX_W-1:0] edge_to;
    logic [WEIGHT_W-1:0]   edge_weight_out;
    logic [COST_W-1:0]     total_cost;
    logic                  no_path;
    logic                  last_edge;
  } result_t;

  typedef struct packed {
    logic start;
    logic sample;
    logic eligible;
  } cmp_ctrl_t;

endpackage

// ----- hw/rtl/pmst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pmst_ram #(
  parameter int WIDTH  = 10,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/pmst_min_unit.sv -----
// Shared compare unit: keeps the lightest eligible edge seen in one scan.
// Depends on pmst_pkg for widths, the no-edge limit and the control struct.
module pmst_min_unit #(
  parameter int NODE_W = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pmst_pkg::cmp_ctrl_t           ctrl,
  input  logic [pmst_pkg::WEIGHT_W-1:0] weight,
  input  logic [NODE_W-1:0]             from_node,
  input  logic [NODE_W-1:0]             to_node,
  output logic [pmst_pkg::WEIGHT_W-1:0] best,
  output logic [NODE_W-1:0]             best_from,
  output logic [NODE_W-1:0]             best_to,
  output logic                          found
);

  logic take;

  assign take = ctrl.sample && ctrl.eligible && (weight != '0) && (weight < best);

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      best  <= pmst_pkg::NO_EDGE_WEIGHT;
    end else if (ctrl.start) begin
      found <= 1'b0;
      best  <= pmst_pkg::NO_EDGE_WEIGHT;
    end else if (take) begin
      found <= 1'b1;
      best  <= weight;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctrl.start) begin
      best_from <= from_node;
      best_to   <= to_node;
    end
  end

endmodule

// ----- hw/rtl/prim_minimum_spanning_tree_core.sv -----
// Top level of the spanning tree core: sequencer, matrix store and output register.
// Depends on pmst_pkg, pmst_ram, pmst_min_unit and the assertion header.
//
//   channel  direction  handshake                  payload
//   item     in         item_valid / item_ready    pmst_pkg::item_t
//   result   out        result_valid / result_ready pmst_pkg::result_t
//   config   in         cfg_wen                    cfg_wdata (node_count)
//
// The last matrix entry starts a run: each tree edge is found by a scan of all n*n
// matrix entries through the one RAM read port and the shared compare unit, then the
// drain, eval and emit states, where it waits for the result to be taken.
// After reset the matrix is swept to zero, all 2**(2*clog2(MAX_NODES)) entries
// (256 by default), with item_ready low. Item_ready stays low for the whole run.
`include "prim_minimum_spanning_tree_core_assert.svh"

module prim_minimum_spanning_tree_core #(
  parameter int MAX_NODES = pmst_pkg::MAX_NODES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  pmst_pkg::item_t                   item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output pmst_pkg::result_t                 result,
  input  logic                              cfg_wen,
  input  logic [pmst_pkg::NODE_COUNT_W-1:0] cfg_wdata
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int ADDR_W = 2 * NODE_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int IDX_W  = (NODE_W > pmst_pkg::PORT_IDX_W) ? NODE_W : pmst_pkg::PORT_IDX_W;
  localparam int CMP_W  = (CNT_W > pmst_pkg::NODE_COUNT_W) ? CNT_W : pmst_pkg::NODE_COUNT_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_EVAL  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]                          state;
  logic [2:0]                          state_next;
  logic [ADDR_W-1:0]                   clr_addr;
  logic [pmst_pkg::NODE_COUNT_W-1:0]   node_count;
  logic [CNT_W-1:0]                    n_use;
  logic [CNT_W-1:0]                    step;
  logic [NODE_W-1:0]                   scan_i;
  logic [NODE_W-1:0]                   scan_j;
  logic                                rd_pend;
  logic [NODE_W-1:0]                   rd_i;
  logic [NODE_W-1:0]                   rd_j;
  logic [MAX_NODES-1:0]                visited;
  logic [pmst_pkg::COST_W-1:0]         cost_sum;

  logic                                item_acc;
  logic                                run_start;
  logic                                next_step;
  logic [IDX_W-1:0]                    row_ext;
  logic [IDX_W-1:0]                    col_ext;
  logic                                in_range;
  logic                                ram_we;
  logic [ADDR_W-1:0]                   ram_waddr;
  logic [pmst_pkg::WEIGHT_W-1:0]       ram_wdata;
  logic [pmst_pkg::WEIGHT_W-1:0]       ram_rdata;
  logic [CMP_W-1:0]                    nc_ext;
  logic [CNT_W-1:0]                    n_clamp;
  logic                                last_i;
  logic                                last_j;
  pmst_pkg::cmp_ctrl_t                 cmp_ctrl;
  logic [pmst_pkg::WEIGHT_W-1:0]       best;
  logic [NODE_W-1:0]                   best_from;
  logic [NODE_W-1:0]                   best_to;
  logic                                found;
  logic [pmst_pkg::COST_W:0]           cost_wide;
  logic [pmst_pkg::COST_W-1:0]         cost_next;
  logic [IDX_W-1:0]                    from_ext;
  logic [IDX_W-1:0]                    to_ext;

  assign item_ready = (state == ST_LOAD);
  assign item_acc   = item_valid && item_ready;
  assign run_start  = item_acc && item.last_entry;
  assign next_step  = (state == ST_EMIT) && result_ready && !result.last_edge;

  assign row_ext  = IDX_W'(item.row_index);
  assign col_ext  = IDX_W'(item.col_index);
  assign in_range = ({1'b0, row_ext} < (IDX_W + 1)'(MAX_NODES)) &&
                    ({1'b0, col_ext} < (IDX_W + 1)'(MAX_NODES));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    if (state == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (item_acc && in_range) begin
      ram_we    = 1'b1;
      ram_waddr = {row_ext[NODE_W-1:0], col_ext[NODE_W-1:0]};
      ram_wdata = item.edge_weight_in;
    end
  end

  pmst_ram #(
    .WIDTH  (pmst_pkg::WEIGHT_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr ({scan_i, scan_j}),
    .rdata (ram_rdata)
  );

  assign cmp_ctrl.start    = run_start || next_step;
  assign cmp_ctrl.sample   = rd_pend;
  assign cmp_ctrl.eligible = visited[rd_i] && !visited[rd_j];

  pmst_min_unit #(
    .NODE_W (NODE_W)
  ) u_min (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (cmp_ctrl),
    .weight    (ram_rdata),
    .from_node (rd_i),
    .to_node   (rd_j),
    .best      (best),
    .best_from (best_from),
    .best_to   (best_to),
    .found     (found)
  );

  assign nc_ext = CMP_W'(node_count);
  always_comb begin
    priority if (nc_ext < CMP_W'(2)) begin
      n_clamp = CNT_W'(2);
    end else if (nc_ext > CMP_W'(MAX_NODES)) begin
      n_clamp = CNT_W'(MAX_NODES);
    end else begin
      n_clamp = nc_ext[CNT_W-1:0];
    end
  end

  assign last_i = (CNT_W'(scan_i) == n_use - CNT_W'(1));
  assign last_j = (CNT_W'(scan_j) == n_use - CNT_W'(1));

  assign cost_wide = {1'b0, cost_sum} + (pmst_pkg::COST_W + 1)'(best);
  assign cost_next = cost_wide[pmst_pkg::COST_W] ? pmst_pkg::COST_MAX
                                                 : cost_wide[pmst_pkg::COST_W-1:0];
  assign from_ext  = IDX_W'(best_from);
  assign to_ext    = IDX_W'(best_to);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (run_start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_i && last_j) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_EVAL;
      ST_EVAL:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (result_ready) begin
          state_next = result.last_edge ? ST_LOAD : ST_SCAN;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      node_count   <= pmst_pkg::NODE_COUNT_RESET;
      rd_pend      <= 1'b0;
      result_valid <= 1'b0;
      visited      <= '0;
      cost_sum     <= '0;
      step         <= '0;
      n_use        <= CNT_W'(2);
      scan_i       <= '0;
      scan_j       <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ST_SCAN);
      if (cfg_wen) begin
        node_count <= cfg_wdata;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (run_start) begin
        visited  <= MAX_NODES'(1);
        cost_sum <= '0;
        step     <= '0;
        n_use    <= n_clamp;
      end
      if (run_start || next_step) begin
        scan_i <= '0;
        scan_j <= '0;
      end else if (state == ST_SCAN) begin
        if (last_j) begin
          scan_j <= '0;
          if (!last_i) begin
            scan_i <= scan_i + NODE_W'(1);
          end
        end else begin
          scan_j <= scan_j + NODE_W'(1);
        end
      end
      if (state == ST_EVAL) begin
        result_valid <= 1'b1;
        if (found) begin
          visited  <= visited | (MAX_NODES'(1) << best_to);
          cost_sum <= cost_next;
          step     <= step + CNT_W'(1);
        end
      end else if ((state == ST_EMIT) && result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_i <= scan_i;
    rd_j <= scan_j;
    if (state == ST_EVAL) begin
      if (found) begin
        result.edge_from       <= from_ext[pmst_pkg::PORT_IDX_W-1:0];
        result.edge_to         <= to_ext[pmst_pkg::PORT_IDX_W-1:0];
        result.edge_weight_out <= best;
        result.total_cost      <= cost_next;
        result.no_path         <= 1'b0;
        result.last_edge       <= (step + CNT_W'(2) == n_use);
      end else begin
        result.edge_from       <= '0;
        result.edge_to         <= '0;
        result.edge_weight_out <= '0;
        result.total_cost      <= cost_sum;
        result.no_path         <= 1'b1;
        result.last_edge       <= 1'b1;
      end
    end
  end

  `PMST_ASSERT_IMP(a_ready_excl, clk, rst, item_ready, !result_valid)
  `PMST_ASSERT_IMP(a_nopath_last, clk, rst, result_valid && result.no_path, result.last_edge)
  `PMST_ASSERT_NXT(a_last_reload, clk, rst, result_valid && result_ready && result.last_edge, item_ready)
  `PMST_ASSERT_IMP(a_root_visited, clk, rst, state == ST_SCAN, visited[0])

endmodule

// ----- tb/prim_minimum_spanning_tree_core_tb.sv -----
// Testbench for the spanning tree core: loads adjacency matrices, runs tree searches
// and checks every emitted edge against a built-in tree predictor.
// Depends on pmst_pkg and prim_minimum_spanning_tree_core.
module prim_minimum_spanning_tree_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmst_pkg::*;

  localparam int NODES          = MAX_NODES_DEFAULT;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TAIL_CYCLES    = 600;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ENTRIES  = 15;

  class mst_scoreboard;
    logic [WEIGHT_W-1:0]     weights [NODES][NODES];
    logic [NODE_COUNT_W-1:0] node_count;
    result_t                 expected_edges [$];
    int                      errors;

    function new();
      foreach (weights[r, c]) weights[r][c] = '0;
      node_count = NODE_COUNT_RESET;
      errors = 0;
    endfunction

    function void set_node_count(logic [NODE_COUNT_W-1:0] v);
      node_count = v;
    endfunction

    function int pending();
      return expected_edges.size();
    endfunction

    // Store the entry; on the last one grow the tree from node 0.
    function void note_entry(item_t it);
      int               span;
      int               best;
      int               bi;
      int               bj;
      int               cost;
      bit               found;
      logic [NODES-1:0] visited;
      result_t          r;
      weights[it.row_index][it.col_index] = it.edge_weight_in;
      if (!it.last_entry) return;
      span = node_count;
      if (span < 2) span = 2;
      if (span > NODES) span = NODES;
      visited = NODES'(1);
      cost = 0;
      for (int hop = 1; hop < span; hop++) begin
        best = NO_EDGE_WEIGHT;
        bi = 0;
        bj = 0;
        found = 0;
        for (int i = 0; i < span; i++) begin
          for (int j = 0; j < span; j++) begin
            if (visited[i] && !visited[j] && weights[i][j] != 0 && weights[i][j] < best) begin
              best = weights[i][j];
              bi = i;
              bj = j;
              found = 1;
            end
          end
        end
        r = '0;
        if (!found) begin
          r.total_cost = COST_W'(cost);
          r.no_path = 1'b1;
          r.last_edge = 1'b1;
          expected_edges.push_back(r);
          return;
        end
        visited[bj] = 1'b1;
        cost += best;
        if (cost > COST_MAX) cost = COST_MAX;
        r.edge_from = PORT_IDX_W'(bi);
        r.edge_to = PORT_IDX_W'(bj);
        r.edge_weight_out = WEIGHT_W'(best);
        r.total_cost = COST_W'(cost);
        r.last_edge = (hop + 1 == span);
        expected_edges.push_back(r);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_edges.size() == 0) begin
        $error("result beat with nothing expected: %p", got);
        errors++;
        return;
      end
      want = expected_edges.pop_front();
      if (got.edge_from !== want.edge_from) begin
        $error("edge_from: expected %0d, actual %0d", want.edge_from, got.edge_from);
        errors++;
      end
      if (got.edge_to !== want.edge_to) begin
        $error("edge_to: expected %0d, actual %0d", want.edge_to, got.edge_to);
        errors++;
      end
      if (got.edge_weight_out !== want.edge_weight_out) begin
        $error("edge_weight_out: expected %0d, actual %0d", want.edge_weight_out,
               got.edge_weight_out);
        errors++;
      end
      if (got.total_cost !== want.total_cost) begin
        $error("total_cost: expected %0d, actual %0d", want.total_cost, got.total_cost);
        errors++;
      end
      if (got.no_path !== want.no_path) begin
        $error("no_path: expected %0d, actual %0d", want.no_path, got.no_path);
        errors++;
      end
      if (got.last_edge !== want.last_edge) begin
        $error("last_edge: expected %0d, actual %0d", want.last_edge, got.last_edge);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    item_valid;
  logic                    item_ready;
  item_t                   item;
  logic                    result_valid;
  logic                    result_ready;
  result_t                 result;
  logic                    cfg_wen;
  logic [NODE_COUNT_W-1:0] cfg_wdata;

  mst_scoreboard board;
  int            entries_sent;
  int            tx_idle_pct;
  int            rx_idle_pct;
  bit            hold_req;
  int            stall_cycles;
  int            node_plan [12] = '{5, 3, 0, 16, 6, 17, 2, 8, 1, 31, 4, 11};

  prim_minimum_spanning_tree_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic bit roll(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic int span_of(int v);
    if (v < 2) return 2;
    if (v > NODES) return NODES;
    return v;
  endfunction

  function automatic item_t make_entry(int r, int c, int w, bit last);
    item_t it;
    it.row_index = PORT_IDX_W'(r);
    it.col_index = PORT_IDX_W'(c);
    it.edge_weight_in = WEIGHT_W'(w);
    it.last_entry = last;
    return it;
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight(bit usable);
    if (!usable && roll(25)) begin
      if (roll(40)) return '0;
      return WEIGHT_W'($urandom_range(1023, 1000));
    end
    if (roll(30)) return WEIGHT_W'($urandom_range(8, 1));
    return WEIGHT_W'($urandom_range(999, 1));
  endfunction

  task automatic send_entry(item_t it);
    if (entries_sent < 70) begin
      tx_idle_pct = 28;
      rx_idle_pct = 54;
    end else if (entries_sent < 140) begin
      tx_idle_pct = 54;
      rx_idle_pct = 28;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    @(negedge clk);
    while (roll(tx_idle_pct)) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    board.note_entry(it);
    entries_sent++;
  endtask

  // Tree-shaped graphs link every node to an earlier one; the rest are sparse and may break apart.
  task automatic load_graph(int span);
    bit tree_shaped;
    tree_shaped = roll(80);
    for (int j = 1; j < span; j++) begin
      if (tree_shaped || roll(60))
        send_entry(make_entry($urandom_range(j - 1, 0), j, pick_weight(tree_shaped), 1'b0));
    end
    repeat ($urandom_range(3, 0))
      send_entry(make_entry($urandom_range(15, 0), $urandom_range(15, 0),
                            $urandom_range(1023, 0), 1'b0));
    send_entry(make_entry($urandom_range(span - 1, 0), $urandom_range(span - 1, 0),
                          pick_weight(1'b0), 1'b1));
  endtask

  task automatic settle_and_set_nodes(int v);
    @(negedge clk);
    item_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= NODE_COUNT_W'(v);
    board.set_node_count(NODE_COUNT_W'(v));
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      result_ready <= !roll(rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) board.check_result(result);
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_wen)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int start;
    board = new();
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    entries_sent = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // heavy weights, extreme indexes, then a graph that breaks apart
    send_entry(make_entry(15, 15, 0, 1'b0));
    send_entry(make_entry(0, 15, 1023, 1'b0));
    send_entry(make_entry(0, 1, 1000, 1'b0));
    send_entry(make_entry(0, 2, 999, 1'b0));
    send_entry(make_entry(2, 15, 1, 1'b1));

    // node counts below range act as two nodes
    settle_and_set_nodes(0);
    send_entry(make_entry(1, 0, 5, 1'b0));
    send_entry(make_entry(0, 1, 3, 1'b1));
    send_entry(make_entry(0, 1, 0, 1'b1));
    settle_and_set_nodes(1);
    send_entry(make_entry(0, 1, 7, 1'b1));

    // ties on target node and on source node
    settle_and_set_nodes(4);
    send_entry(make_entry(0, 1, 5, 1'b0));
    send_entry(make_entry(0, 2, 5, 1'b0));
    send_entry(make_entry(1, 3, 2, 1'b0));
    send_entry(make_entry(1, 2, 5, 1'b0));
    send_entry(make_entry(2, 3, 2, 1'b1));

    foreach (node_plan[p]) begin
      settle_and_set_nodes(node_plan[p]);
      if (p == 1) hold_req = 1'b1;
      start = entries_sent;
      while (entries_sent - start < PHASE_ENTRIES) load_graph(span_of(node_plan[p]));
    end

    @(negedge clk);
    item_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
